>>> rtl/poi_pkg.sv
// Package with the beat types, CORDIC constants and sequencer states of the odometry integrator.
`timescale 1ns / 1ps
package poi_pkg;

   typedef struct packed {
      logic               cmd;
      logic signed [15:0] speed;
      logic signed [15:0] steer_angle;
      logic [3:0]         wheel_signs;
      logic [19:0]        elapsed_us;
   } req_type;

   typedef struct packed {
      logic signed [47:0] pos_x;
      logic signed [47:0] pos_y;
      logic [31:0]        heading;
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_z;
   } rsp_type;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam int          ATAN_ENTRIES   = 24;
   localparam logic [23:0] TURN_GAIN_RST  = 24'd140588;
   localparam logic signed [31:0] CORDIC_START = 32'sd163008218;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIST,
      ST_TURN_MUL,
      ST_TURN_ADD,
      ST_CORD_LOAD,
      ST_CORD_RUN,
      ST_MOVE_X_LO,
      ST_MOVE_X_HI,
      ST_MOVE_Y_LO,
      ST_MOVE_Y_HI,
      ST_QUAT_LOAD,
      ST_QUAT_RUN,
      ST_DONE
   } state_type;

   function automatic logic signed [31:0] atan_value(input logic [4:0] idx);
      logic signed [31:0] v;
      case (idx)
         5'd0:  v = 32'sd536870912;
         5'd1:  v = 32'sd316933406;
         5'd2:  v = 32'sd167458907;
         5'd3:  v = 32'sd85004756;
         5'd4:  v = 32'sd42667331;
         5'd5:  v = 32'sd21354465;
         5'd6:  v = 32'sd10679838;
         5'd7:  v = 32'sd5340245;
         5'd8:  v = 32'sd2670163;
         5'd9:  v = 32'sd1335087;
         5'd10: v = 32'sd667544;
         5'd11: v = 32'sd333772;
         5'd12: v = 32'sd166886;
         5'd13: v = 32'sd83443;
         5'd14: v = 32'sd41722;
         5'd15: v = 32'sd20861;
         5'd16: v = 32'sd10430;
         5'd17: v = 32'sd5215;
         5'd18: v = 32'sd2608;
         5'd19: v = 32'sd1304;
         5'd20: v = 32'sd652;
         5'd21: v = 32'sd326;
         5'd22: v = 32'sd163;
         5'd23: v = 32'sd81;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/planar_odometry_integrator_unit.sv
// Top level of the planar dead-reckoning odometry integrator.
`timescale 1ns / 1ps
//
//   Channel  Dir  Handshake          Payload
//   req      in   req_valid/ready    req_data  (req_type: cmd, speed, steer, signs, time)
//   rsp      out  rsp_valid/ready    rsp_data  (rsp_type: pose and yaw quaternion)
//   csr      in   csr_write_enable   csr_write_data (turn gain, Q8.16)
//
// An update beat only latches its fields; the sequencer stays in ST_IDLE and stays ready.
// A tick beat in straight motion runs, from acceptance to its result beat, the distance
// product, one CORDIC run for the heading, the x and y products, then one CORDIC run for
// the quaternion on the shared shift-add rotator. Turning in place skips the first run
// and the x and y products, and instead subtracts the turn-gain product from the heading.
// Each 37x26 product is registered in prod_ff.
// Reset clears the pose, the held joint state and sets the gain to its reset value.
// A finished result waits in the output register; the next beat can be taken meanwhile,
// but the sequencer holds in its last state until that register is free.
module planar_odometry_integrator_unit
   import poi_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [23:0] csr_write_data
);

   // Effective step count, clamped to the arctangent table.
   localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES :
                          ((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);
   localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);

   state_type state_ff, state_in;

   logic [23:0]        gain_ff;
   logic signed [47:0] px_ff, px_in, py_ff, py_in;
   logic [31:0]        yaw_ff, yaw_in;
   logic signed [15:0] spd_ff, str_ff;
   logic [3:0]         sgn_ff;
   logic [19:0]        el_ff;
   logic signed [36:0] dist_ff;
   logic signed [63:0] prod_ff, prod_in;

   // CORDIC vector state, Q.28 with headroom.
   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [32:0] cz_ff, cz_in;
   logic               neg_ff, neg_in;
   logic [4:0]         step_ff, step_in;
   logic signed [25:0] c24_ff, c24_in, s24_ff, s24_in;
   rsp_type            out_ff, out_in;
   logic               valid_ff, valid_in;

   logic turning;
   assign turning = (sgn_ff[0] ^ sgn_ff[1]) && (sgn_ff[2] ^ sgn_ff[3]);

   // Shared rotator: one micro-rotation per cycle.
   logic signed [31:0] shx, shy, rot_x, rot_y;
   logic signed [32:0] rot_z;
   always_comb begin
      shx = cx_ff >>> step_ff;
      shy = cy_ff >>> step_ff;
      if (!cz_ff[32]) begin
         rot_x = cx_ff - shy;
         rot_y = cy_ff + shx;
         rot_z = cz_ff - 33'(atan_value(step_ff));
      end else begin
         rot_x = cx_ff + shy;
         rot_y = cy_ff - shx;
         rot_z = cz_ff + 33'(atan_value(step_ff));
      end
   end

   // Fold a binary angle into [-pi/2, pi/2].
   function automatic logic [33:0] fold(input logic [31:0] ang);
      logic signed [32:0] z;
      logic               n;
      z = 33'($signed(ang));
      n = 1'b0;
      if (z > 33'sd1073741824) begin
         z = z - 33'sd2147483648;
         n = 1'b1;
      end else if (z < -33'sd1073741824) begin
         z = z + 33'sd2147483648;
         n = 1'b1;
      end
      return {n, z};
   endfunction

   function automatic logic signed [15:0] to_q15(input logic signed [31:0] v);
      logic signed [32:0] r;
      r = (33'(v) + 33'sd4096) >>> 13;
      if (r > 33'sd32767) r = 33'sd32767;
      if (r < -33'sd32768) r = -33'sd32768;
      return r[15:0];
   endfunction

   logic signed [31:0] fx, fy;
   logic [33:0]        fa, fq;
   always_comb begin
      fx = neg_ff ? -cx_ff : cx_ff;
      fy = neg_ff ? -cy_ff : cy_ff;
      fa = fold(({str_ff, 16'h0000} + yaw_ff));
      fq = fold({1'b0, yaw_ff[31:1]});
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (req_valid && req_ready) begin
               state_in = (req_data.cmd == CMD_TICK) ? ST_DIST : ST_IDLE;
            end
         ST_DIST:      state_in = turning ? ST_TURN_MUL : ST_CORD_LOAD;
         ST_TURN_MUL:  state_in = ST_TURN_ADD;
         ST_TURN_ADD:  state_in = ST_QUAT_LOAD;
         ST_CORD_LOAD: state_in = ST_CORD_RUN;
         ST_CORD_RUN:  if (step_ff == LAST_STEP) state_in = ST_MOVE_X_LO;
         ST_MOVE_X_LO: state_in = ST_MOVE_X_HI;
         ST_MOVE_X_HI: state_in = ST_MOVE_Y_LO;
         ST_MOVE_Y_LO: state_in = ST_MOVE_Y_HI;
         ST_MOVE_Y_HI: state_in = ST_QUAT_LOAD;
         ST_QUAT_LOAD: state_in = ST_QUAT_RUN;
         ST_QUAT_RUN:  if (step_ff == LAST_STEP) state_in = ST_DONE;
         ST_DONE:      if (!valid_ff || rsp_ready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      px_in = px_ff; py_in = py_ff; yaw_in = yaw_ff;
      prod_in = prod_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; neg_in = neg_ff; step_in = step_ff;
      c24_in = c24_ff; s24_in = s24_ff;
      out_in = out_ff;
      valid_in = valid_ff && !rsp_ready;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_TURN_MUL: prod_in = 64'(dist_ff) * 64'($signed({1'b0, gain_ff}));
         ST_TURN_ADD: yaw_in = yaw_ff - prod_ff[47:16];
         ST_CORD_LOAD, ST_QUAT_LOAD: begin
            cx_in = CORDIC_START; cy_in = '0; step_in = '0;
            if (state_ff == ST_CORD_LOAD) begin
               cz_in = fa[32:0]; neg_in = fa[33];
            end else begin
               cz_in = fq[32:0]; neg_in = fq[33];
            end
         end
         ST_CORD_RUN, ST_QUAT_RUN: begin
            cx_in = rot_x; cy_in = rot_y; cz_in = rot_z;
            step_in = step_ff + 5'd1;
            if (state_ff == ST_CORD_RUN && step_ff == LAST_STEP) begin
               c24_in = 26'((33'(neg_ff ? -rot_x : rot_x) + 33'sd8) >>> 4);
               s24_in = 26'((33'(neg_ff ? -rot_y : rot_y) + 33'sd8) >>> 4);
            end
         end
         ST_MOVE_X_LO: prod_in = 64'(dist_ff) * 64'(c24_ff);
         ST_MOVE_X_HI: begin
            px_in = px_ff + 48'(prod_ff >>> 24);
            prod_in = 64'(dist_ff) * 64'(s24_ff);
         end
         ST_MOVE_Y_LO: ;
         ST_MOVE_Y_HI: py_in = py_ff + 48'(prod_ff >>> 24);
         ST_DONE: if (!valid_ff || rsp_ready) begin
            out_in.pos_x = px_ff; out_in.pos_y = py_ff; out_in.heading = yaw_ff;
            out_in.quat_w = to_q15(fx); out_in.quat_z = to_q15(fy);
            valid_in = 1'b1;
         end
         default: ;
      endcase
      rsp_valid = valid_ff;
      rsp_data = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; valid_ff <= 1'b0; gain_ff <= TURN_GAIN_RST;
         px_ff <= '0; py_ff <= '0; yaw_ff <= '0;
         spd_ff <= '0; str_ff <= '0; sgn_ff <= '0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in;
         if (csr_write_enable) gain_ff <= csr_write_data;
         px_ff <= px_in; py_ff <= py_in; yaw_ff <= yaw_in;
         if (req_valid && req_ready && req_data.cmd == CMD_UPDATE) begin
            spd_ff <= req_data.speed; str_ff <= req_data.steer_angle;
            sgn_ff <= req_data.wheel_signs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) el_ff <= req_data.elapsed_us;
      if (state_ff == ST_DIST) dist_ff <= 37'(spd_ff) * 37'($signed({1'b0, el_ff}));
      prod_ff <= prod_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; neg_ff <= neg_in; step_ff <= step_in;
      c24_ff <= c24_in; s24_ff <= s24_in; out_ff <= out_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && rsp_valid && !rsp_ready |=> state_ff == ST_DONE)
      else $error("finished result overwrote a pending result");
   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready)
      else $error("ready while busy");

endmodule
